FILE: rtl/ptw_pkg.sv
// Package with item types, codes and state encoding for the page table walker.
package ptw_pkg;

  localparam int unsigned TableEntries = 512;
  localparam int unsigned IdxW         = 9;
  localparam int unsigned UserLimit    = 256;
  localparam int unsigned AddrW        = 18;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WALK    = 2'd2;
  localparam logic [1:0] OP_CLEANUP = 2'd3;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_FOUND = 3'd1;
  localparam logic [2:0] KIND_FAULT = 3'd2;
  localparam logic [2:0] KIND_FREED = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_ABSENT  = 2'd1;
  localparam logic [1:0] FAULT_PS_ROOT = 2'd2;
  localparam logic [1:0] FAULT_OUTSIDE = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] virtual_address;
    logic [14:0] word_index;
    logic [63:0] write_data;
  } item_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] entry_value;
    logic [17:0] entry_address;
    logic [1:0]  leaf_level;
    logic [1:0]  fault_code;
    logic [5:0]  freed_frame;
    logic        last;
  } item_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/page_table_walker.sv
// Top level of the page table walker: table memory, walk and cleanup sequencer.
// A write completes while the block stays idle; a read result is registered from RD_WAIT.
// A walk makes up to four dependent reads, each through WALK_RD and WALK_CHK.
// Cleanup scans each table that it may free entry by entry; a live entry ends the scan.
// busy is high through the last result; the next item is taken in the cycle after it.
// rst is synchronous; it clears the sequencer and root_frame; table memory is not cleared.
module page_table_walker #(
  parameter int unsigned MEM_FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ptw_pkg::item_in_t   item_in,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data,
  output logic                result_valid,
  output ptw_pkg::item_out_t  result
);

  localparam int unsigned FrameW = (MEM_FRAMES > 1) ? $clog2(MEM_FRAMES) : 1;
  localparam int unsigned FrmW   = (FrameW > 6) ? FrameW : 6;
  localparam int unsigned WordW  = FrameW + ptw_pkg::IdxW;
  localparam int unsigned Words  = MEM_FRAMES * ptw_pkg::TableEntries;

  // Table memory, one port, registered read.
  logic [63:0] mem [Words];
  logic [63:0] rdata;
  logic        mem_we;
  logic [WordW-1:0] mem_addr;
  logic [63:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // Registers.
  ptw_pkg::state_t state, state_next;
  logic [5:0]  root_frame;
  logic [1:0]  op;
  logic [47:0] va;
  logic [1:0]  level, level_next;        // 3 PML4, 2 PDPT, 1 PD, 0 PT
  logic [FrmW-1:0] frm [4];              // frame of each level's table
  logic [FrmW-1:0] frm_next;
  logic        ok_rd, ok_rd_next;
  logic [8:0]  scan, scan_next;
  logic        result_valid_next;
  ptw_pkg::item_out_t result_next;

  // Index of the virtual address at a level.
  function automatic logic [8:0] vidx(input logic [47:0] a, input logic [1:0] l);
    logic [8:0] r;
    case (l)
      2'd3:    r = a[47:39];
      2'd2:    r = a[38:30];
      2'd1:    r = a[29:21];
      default: r = a[20:12];
    endcase
    return r;
  endfunction

  logic [8:0] cur_idx;
  logic [39:0] nf;
  logic nf_ok, cur_ok, root_ok;
  logic [WordW-1:0] wi_trunc;
  logic wi_ok;
  logic keep_pdpt;

  assign cur_idx = vidx(va, level);
  assign nf      = rdata[51:12];
  assign nf_ok   = (nf < 40'(MEM_FRAMES));
  assign root_ok = ({26'd0, root_frame} < 32'(MEM_FRAMES));
  assign cur_ok  = (32'(frm[level]) < 32'(MEM_FRAMES));
  assign wi_trunc = WordW'(item_in.word_index);
  assign wi_ok   = ({17'd0, item_in.word_index} < 32'(Words));
  assign busy    = (state != ptw_pkg::ST_IDLE);
  // The PDPT under PML4 slot 0 or a kernel slot is never freed.
  assign keep_pdpt = (level == 2'd2) &&
                     (va[47:39] == 9'd0 || va[47:39] >= 9'(ptw_pkg::UserLimit));

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptw_pkg::ST_IDLE;
      root_frame   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (cfg_we) begin
        root_frame <= cfg_data;
      end
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    result <= result_next;
    level  <= level_next;
    scan   <= scan_next;
    ok_rd  <= ok_rd_next;
    if (state == ptw_pkg::ST_IDLE && start) begin
      op     <= item_in.op;
      va     <= item_in.virtual_address;
      frm[3] <= FrmW'(root_frame);
    end
    if (state == ptw_pkg::ST_WALK_CHK && level != 2'd0) begin
      frm[level - 2'd1] <= frm_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ptw_pkg::ST_IDLE: begin
        if (start) begin
          case (item_in.op)
            ptw_pkg::OP_WRITE: state_next = ptw_pkg::ST_IDLE;
            ptw_pkg::OP_READ:  state_next = ptw_pkg::ST_RD_WAIT;
            default:           state_next = ptw_pkg::ST_WALK_RD;
          endcase
        end
      end
      ptw_pkg::ST_RD_WAIT: state_next = ptw_pkg::ST_DONE;
      ptw_pkg::ST_WALK_RD: begin
        if (!cur_ok) state_next = ptw_pkg::ST_DONE;
        else         state_next = ptw_pkg::ST_WALK_CHK;
      end
      ptw_pkg::ST_WALK_CHK: begin
        if (level == 2'd0) begin
          state_next = (op == ptw_pkg::OP_WALK) ? ptw_pkg::ST_DONE : ptw_pkg::ST_SCAN_RD;
        end else if (!rdata[0] || rdata[7]) begin
          state_next = ptw_pkg::ST_DONE;
        end else if (!nf_ok) begin
          state_next = ptw_pkg::ST_DONE;
        end else if (op == ptw_pkg::OP_CLEANUP && level == 2'd1) begin
          state_next = ptw_pkg::ST_SCAN_RD;
        end else begin
          state_next = ptw_pkg::ST_WALK_RD;
        end
      end
      ptw_pkg::ST_SCAN_RD: state_next = ptw_pkg::ST_SCAN_CHK;
      // rdata lags scan by one entry; entry 511 arrives once scan wraps to 0.
      ptw_pkg::ST_SCAN_CHK: begin
        if (rdata[0]) state_next = ptw_pkg::ST_DONE;
        else if (scan == 9'd0) state_next = keep_pdpt ? ptw_pkg::ST_DONE : ptw_pkg::ST_CLEAR;
        else state_next = ptw_pkg::ST_SCAN_CHK;
      end
      ptw_pkg::ST_CLEAR: begin
        if (level == 2'd2) state_next = ptw_pkg::ST_DONE;
        else state_next = ptw_pkg::ST_SCAN_RD;
      end
      ptw_pkg::ST_DONE: begin
        if (result_valid && !result.last) state_next = ptw_pkg::ST_DONE;
        else state_next = ptw_pkg::ST_IDLE;
      end
      default: state_next = ptw_pkg::ST_IDLE;
    endcase
  end

  // Outputs, memory port and data path.
  always_comb begin
    mem_we            = 1'b0;
    mem_addr          = {frm[level][FrameW-1:0], cur_idx};
    mem_wdata         = '0;
    level_next        = level;
    scan_next         = scan;
    ok_rd_next        = ok_rd;
    frm_next          = nf[FrmW-1:0];
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.last  = 1'b1;
    case (state)
      ptw_pkg::ST_IDLE: begin
        mem_addr   = wi_trunc;
        mem_wdata  = item_in.write_data;
        mem_we     = start && (item_in.op == ptw_pkg::OP_WRITE) && wi_ok;
        ok_rd_next = wi_ok;
        level_next = 2'd3;
        if (start && item_in.op == ptw_pkg::OP_CLEANUP && !root_ok) begin
          level_next = 2'd3;
        end
      end
      ptw_pkg::ST_RD_WAIT: begin
        result_valid_next       = 1'b1;
        result_next.kind        = ptw_pkg::KIND_READ;
        result_next.entry_value = ok_rd ? rdata : 64'd0;
      end
      ptw_pkg::ST_WALK_RD: begin
        if (!cur_ok) begin
          result_valid_next = 1'b1;
          if (op == ptw_pkg::OP_WALK) begin
            result_next.kind       = ptw_pkg::KIND_FAULT;
            result_next.fault_code = ptw_pkg::FAULT_OUTSIDE;
          end else begin
            result_next.kind = ptw_pkg::KIND_DONE;
          end
        end
      end
      ptw_pkg::ST_WALK_CHK: begin
        if (op == ptw_pkg::OP_WALK) begin
          result_next.kind = ptw_pkg::KIND_FAULT;
          if (level == 2'd0 || (rdata[0] && rdata[7] && level != 2'd3)) begin
            result_valid_next         = 1'b1;
            result_next.kind          = ptw_pkg::KIND_FOUND;
            result_next.entry_value   = rdata;
            result_next.entry_address = {frm[level][5:0], cur_idx, 3'b000};
            result_next.leaf_level    = level;
          end else if (!rdata[0]) begin
            result_valid_next      = 1'b1;
            result_next.fault_code = ptw_pkg::FAULT_ABSENT;
          end else if (rdata[7]) begin
            result_valid_next      = 1'b1;
            result_next.fault_code = ptw_pkg::FAULT_PS_ROOT;
          end else if (!nf_ok) begin
            result_valid_next      = 1'b1;
            result_next.fault_code = ptw_pkg::FAULT_OUTSIDE;
          end else begin
            level_next = level - 2'd1;
          end
        end else begin
          result_next.kind = ptw_pkg::KIND_DONE;
          if (!rdata[0] || rdata[7] || !nf_ok) begin
            result_valid_next = 1'b1;
          end else begin
            level_next = level - 2'd1;
          end
          scan_next = '0;
        end
      end
      ptw_pkg::ST_SCAN_RD: begin
        mem_addr  = {frm[level][FrameW-1:0], 9'd0};
        scan_next = 9'd1;
      end
      ptw_pkg::ST_SCAN_CHK: begin
        mem_addr  = {frm[level][FrameW-1:0], scan};
        scan_next = scan + 9'd1;
        if (rdata[0]) begin
          result_valid_next = 1'b1;
          result_next.kind  = ptw_pkg::KIND_DONE;
        end else if (scan == 9'd0 && keep_pdpt) begin
          result_valid_next = 1'b1;
          result_next.kind  = ptw_pkg::KIND_DONE;
        end
      end
      ptw_pkg::ST_CLEAR: begin
        // Free the table at this level and clear the entry above that points to it.
        mem_we      = 1'b1;
        mem_addr    = {frm[level + 2'd1][FrameW-1:0], vidx(va, level + 2'd1)};
        result_valid_next       = 1'b1;
        result_next.kind        = ptw_pkg::KIND_FREED;
        result_next.freed_frame = frm[level][5:0];
        result_next.last        = 1'b0;
        level_next              = level + 2'd1;
      end
      ptw_pkg::ST_DONE: begin
        // The done item follows the last freed frame.
        if (result_valid && !result.last) begin
          result_valid_next = 1'b1;
          result_next.kind  = ptw_pkg::KIND_DONE;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A result only appears while an item is in progress or just finishing.
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without item");
  // A freed frame is never the final result.
  a_freed_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == ptw_pkg::KIND_FREED |-> !result.last)
    else $error("freed marked last");
  // A write leaves the block idle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item_in.op == ptw_pkg::OP_WRITE |=> !busy)
    else $error("write held busy");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the page table walker: memory access, walks, cleanup.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MemWords = 64 * 512;
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  ptw_pkg::item_in_t item_in;
  logic cfg_we;
  logic [5:0] cfg_data;
  logic result_valid;
  ptw_pkg::item_out_t result;

  page_table_walker uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item_in(item_in),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table memory and the root register.
  logic [63:0] shadow_mem [MemWords];
  logic [5:0] shadow_root;
  ptw_pkg::item_out_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;

  function automatic ptw_pkg::item_out_t mk_result(logic [2:0] kind, logic [63:0] val,
                                                   logic [17:0] addr, logic [1:0] lvl,
                                                   logic [1:0] fault, logic [5:0] frame,
                                                   logic last);
    ptw_pkg::item_out_t r;
    r.kind = kind;
    r.entry_value = val;
    r.entry_address = addr;
    r.leaf_level = lvl;
    r.fault_code = fault;
    r.freed_frame = frame;
    r.last = last;
    return r;
  endfunction

  function automatic logic [39:0] frame_of(logic [63:0] e);
    return e[51:12];
  endfunction

  function automatic bit table_clear(int f);
    for (int i = 0; i < 512; i++) begin
      if (shadow_mem[f * 512 + i][0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk a virtual address through the shadow tables and queue the outcome.
  function automatic void walk_address(logic [47:0] va);
    logic [39:0] f;
    logic [63:0] e;
    int idx;
    f = 40'(shadow_root);
    for (int lvl = 3; lvl >= 0; lvl--) begin
      if (f >= 64) begin
        pending_results.push_back(mk_result(ptw_pkg::KIND_FAULT, 0, 0, 0,
                                            ptw_pkg::FAULT_OUTSIDE, 0, 1));
        return;
      end
      idx = int'(va[12 + 9 * lvl +: 9]);
      e = shadow_mem[f * 512 + idx];
      if (lvl == 0) begin
        // The PT leaf is reported whatever its present bit holds.
        pending_results.push_back(mk_result(ptw_pkg::KIND_FOUND, e, 18'(f * 4096 + idx * 8),
                                            0, ptw_pkg::FAULT_NONE, 0, 1));
        return;
      end
      if (!e[0]) begin
        pending_results.push_back(mk_result(ptw_pkg::KIND_FAULT, 0, 0, 0,
                                            ptw_pkg::FAULT_ABSENT, 0, 1));
        return;
      end
      if (e[7]) begin
        if (lvl == 3)
          pending_results.push_back(mk_result(ptw_pkg::KIND_FAULT, 0, 0, 0,
                                              ptw_pkg::FAULT_PS_ROOT, 0, 1));
        else
          pending_results.push_back(mk_result(ptw_pkg::KIND_FOUND, e,
                                              18'(f * 4096 + idx * 8), 2'(lvl),
                                              ptw_pkg::FAULT_NONE, 0, 1));
        return;
      end
      f = frame_of(e);
    end
  endfunction

  // Free emptied tables bottom up, then report completion.
  function automatic void release_tables(logic [47:0] va);
    logic [39:0] fr [4];
    int idx [4];
    logic [63:0] e;
    bit ok;
    ok = 1'b1;
    fr[3] = 40'(shadow_root);
    for (int lvl = 3; lvl >= 1; lvl--) begin
      idx[lvl] = int'(va[12 + 9 * lvl +: 9]);
      if (ok) begin
        e = shadow_mem[fr[lvl] * 512 + idx[lvl]];
        if (!e[0] || e[7] || frame_of(e) >= 64) ok = 1'b0;
        else fr[lvl - 1] = frame_of(e);
      end
    end
    for (int lvl = 0; lvl <= 2 && ok; lvl++) begin
      if (!table_clear(int'(fr[lvl]))) ok = 1'b0;
      else if (lvl == 2 && (idx[3] == 0 || idx[3] >= ptw_pkg::UserLimit)) ok = 1'b0;
      else begin
        pending_results.push_back(mk_result(ptw_pkg::KIND_FREED, 0, 0, 0, ptw_pkg::FAULT_NONE,
                                            6'(fr[lvl]), 0));
        shadow_mem[fr[lvl + 1] * 512 + idx[lvl + 1]] = '0;
      end
    end
    pending_results.push_back(mk_result(ptw_pkg::KIND_DONE, 0, 0, 0, ptw_pkg::FAULT_NONE,
                                        0, 1));
  endfunction

  function automatic void predict_item(ptw_pkg::item_in_t it);
    case (it.op)
      ptw_pkg::OP_WRITE: shadow_mem[it.word_index] = it.write_data;
      ptw_pkg::OP_READ: pending_results.push_back(mk_result(ptw_pkg::KIND_READ,
                                                            shadow_mem[it.word_index],
                                                            0, 0, ptw_pkg::FAULT_NONE, 0, 1));
      ptw_pkg::OP_WALK: walk_address(it.virtual_address);
      default: release_tables(it.virtual_address);
    endcase
  endfunction

  // Send one item, wait for acceptance, and take a random gap at burst ends.
  task automatic send_item(logic [1:0] op, logic [47:0] va, logic [14:0] widx,
                           logic [63:0] data);
    ptw_pkg::item_in_t it;
    it.op = op;
    it.virtual_address = va;
    it.word_index = widx;
    it.write_data = data;
    item_in <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_item(it);
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_word(int widx, logic [63:0] data);
    send_item(ptw_pkg::OP_WRITE, 48'($urandom), 15'(widx), data);
  endtask

  // Wait until the block is idle with nothing outstanding.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_root(logic [5:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_root = value;
  endtask

  function automatic logic [63:0] make_entry(logic [39:0] frame, bit ps);
    logic [11:0] flags;
    flags = (12'($urandom) & 12'hF7E) | 12'h1 | (ps ? 12'h080 : 12'h0);
    return {12'($urandom), frame, flags};
  endfunction

  function automatic logic [47:0] make_va(int i4, int i3, int i2, int i1);
    return {9'(i4), 9'(i3), 9'(i2), 9'(i1), 12'($urandom)};
  endfunction

  // Every word is written once so that no walk or scan reads unwritten memory.
  task automatic test_clear_memory();
    gaps_on = 1'b0;
    for (int w = 0; w < MemWords; w++) write_word(w, '0);
    gaps_on = 1'b1;
  endtask

  task automatic test_directed();
    set_root(6'd0);
    write_word(1, make_entry(1, 0));
    write_word(512 + 2, make_entry(2, 0));
    write_word(1024 + 3, make_entry(3, 0));
    write_word(1536 + 4, {$urandom, $urandom} | 64'h1);
    send_item(ptw_pkg::OP_WALK, make_va(1, 2, 3, 4), 0, 0);
    // A leaf that is not present is still reported as found.
    send_item(ptw_pkg::OP_WALK, make_va(1, 2, 3, 5), 0, 0);
    send_item(ptw_pkg::OP_WALK, make_va(2, 0, 0, 0), 0, 0);
    send_item(ptw_pkg::OP_WALK, make_va(1, 9, 0, 0), 0, 0);
    write_word(1024 + 6, make_entry(9, 1));
    send_item(ptw_pkg::OP_WALK, make_va(1, 2, 6, 0), 0, 0);
    write_word(512 + 7, make_entry(9, 1));
    send_item(ptw_pkg::OP_WALK, make_va(1, 7, 0, 0), 0, 0);
    write_word(3, make_entry(9, 1));
    send_item(ptw_pkg::OP_WALK, make_va(3, 0, 0, 0), 0, 0);
    write_word(4, make_entry(64, 0));
    send_item(ptw_pkg::OP_WALK, make_va(4, 0, 0, 0), 0, 0);
    write_word(1024 + 8, make_entry(40'hFF_FFFF_FFFF, 0));
    send_item(ptw_pkg::OP_WALK, make_va(1, 2, 8, 0), 0, 0);
    write_word(MemWords - 1, '1);
    send_item(ptw_pkg::OP_READ, 0, 15'(MemWords - 1), 0);
    send_item(ptw_pkg::OP_READ, 0, 0, 0);
    // Cleanup blocked by a live leaf, then a PT freed under a busy PD.
    send_item(ptw_pkg::OP_CLEANUP, make_va(1, 2, 3, 4), 0, 0);
    write_word(1536 + 4, '0);
    send_item(ptw_pkg::OP_CLEANUP, make_va(1, 2, 3, 4), 0, 0);
    // Protected PML4 slots keep their PDPT; an ordinary slot frees all three.
    write_word(0, make_entry(10, 0));
    write_word(10 * 512, make_entry(11, 0));
    write_word(11 * 512, make_entry(12, 0));
    send_item(ptw_pkg::OP_CLEANUP, make_va(0, 0, 0, 0), 0, 0);
    write_word(256, make_entry(13, 0));
    write_word(13 * 512 + 511, make_entry(14, 0));
    write_word(14 * 512 + 511, make_entry(15, 0));
    send_item(ptw_pkg::OP_CLEANUP, make_va(256, 511, 511, 0), 0, 0);
    write_word(5, make_entry(20, 0));
    write_word(20 * 512 + 1, make_entry(21, 0));
    write_word(21 * 512 + 1, make_entry(22, 0));
    send_item(ptw_pkg::OP_CLEANUP, make_va(5, 1, 1, 0), 0, 0);
    set_root(6'd63);
    send_item(ptw_pkg::OP_WALK, make_va(5, 1, 1, 0), 0, 0);
    send_item(ptw_pkg::OP_CLEANUP, make_va(5, 1, 1, 0), 0, 0);
  endtask

  function automatic logic [39:0] pick_frame();
    if ($urandom_range(0, 19) == 0) return {$urandom, 8'($urandom)};
    return 40'($urandom_range(0, 63));
  endfunction

  // Mostly well-formed mappings followed by walks and unmaps, plus noise.
  task automatic test_random();
    int items;
    int next_cfg;
    int i4, i3, i2, i1;
    logic [39:0] f3, f2, f1;
    items = 0;
    next_cfg = 60;
    while (items < 310) begin
      if (items >= next_cfg) begin
        set_root(6'($urandom));
        next_cfg += 60;
      end
      if ($urandom_range(0, 9) < 6) begin
        i4 = $urandom_range(0, 511);
        i3 = $urandom_range(0, 511);
        i2 = $urandom_range(0, 511);
        i1 = $urandom_range(0, 511);
        f3 = pick_frame();
        f2 = pick_frame();
        f1 = pick_frame();
        write_word(shadow_root * 512 + i4, make_entry(f3, $urandom_range(0, 9) == 0));
        if (f3 < 64) write_word(f3 * 512 + i3, make_entry(f2, $urandom_range(0, 7) == 0));
        if (f2 < 64) write_word(f2 * 512 + i2, make_entry(f1, $urandom_range(0, 7) == 0));
        if (f1 < 64) write_word(f1 * 512 + i1, {$urandom, $urandom});
        send_item(ptw_pkg::OP_WALK, make_va(i4, i3, i2, i1), 0, 0);
        send_item(ptw_pkg::OP_WALK, make_va(i4, i3, i2, $urandom_range(0, 511)), 0, 0);
        items += 6;
        if ($urandom_range(0, 1) == 0) begin
          if (f1 < 64) write_word(f1 * 512 + i1, '0);
          send_item(ptw_pkg::OP_CLEANUP, make_va(i4, i3, i2, i1), 0, 0);
          items += 2;
        end
      end else begin
        send_item(2'($urandom), {$urandom, 16'($urandom)}, 15'($urandom), {$urandom, $urandom});
        items++;
      end
    end
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", result);
      end else begin
        if (result !== pending_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result differs: expected %p, got %p", pending_results[0], result);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on cycles in which no item is accepted and no result is returned.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item_in <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    shadow_root = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clear_memory();
    test_directed();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ptw_pkg.sv
rtl/page_table_walker.sv
tb/tb.sv
